/* rtl/core/key_frequency_table_sorted_dump_assert.svh */
// Assertion macros for the key frequency table with sorted dump.
`ifndef KEY_FREQUENCY_TABLE_SORTED_DUMP_ASSERT_SVH
`define KEY_FREQUENCY_TABLE_SORTED_DUMP_ASSERT_SVH

// Checks a consequence in the same cycle as its antecedent.
`define KFSD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define KFSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/kfsd_pkg.sv */
// Shared constants, types and helpers for the key frequency table.
`timescale 1ns / 1ps

package kfsd_pkg;

  localparam int CAPACITY    = 64;
  localparam int COUNT_BITS  = 16;
  localparam int KEY_W       = 8;
  localparam int ADDR_W      = $clog2(CAPACITY);
  localparam int USED_W      = $clog2(CAPACITY + 1);
  localparam int STATUS_W    = 3;
  localparam int OUT_COUNT_W = 16;
  localparam int OUT_POS_W   = 6;
  localparam int COUNT_WIDE  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;
  localparam int POS_WIDE    = (ADDR_W > OUT_POS_W) ? ADDR_W : OUT_POS_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_RAISED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROP   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUMP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

  // One table slot.
  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  // Table write address select.
  typedef enum logic [1:0] {
    WA_PREV,
    WA_IDX,
    WA_USED
  } wsel_t;

  // Table write data select.
  typedef enum logic [1:0] {
    WD_READ,
    WD_CUR,
    WD_NEW,
    WD_BUMP
  } wdat_t;

  // Result source select.
  typedef enum logic [2:0] {
    EM_RAISED,
    EM_NEW,
    EM_DROP,
    EM_DUMP,
    EM_EMPTY
  } emit_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  idx_clr;
    logic  idx_inc;
    logic  we;
    wsel_t wsel;
    wdat_t wdat;
    logic  cur_load;
    logic  swap_clr;
    logic  swap_set;
    logic  used_inc;
    logic  emit;
    emit_t emit_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic action;
    logic empty;
    logic full;
    logic at_last;
    logic hit;
    logic less;
    logic swapped;
  } dp_stat_t;

  // Low bits of a count for the result port, zero extended if narrower.
  function automatic logic [OUT_COUNT_W-1:0] to_out_count(logic [COUNT_BITS-1:0] c);
    logic [COUNT_WIDE-1:0] w;
    w = COUNT_WIDE'(c);
    return w[OUT_COUNT_W-1:0];
  endfunction

  // Low bits of a slot index for the result port, zero extended if narrower.
  function automatic logic [OUT_POS_W-1:0] to_out_pos(logic [ADDR_W-1:0] p);
    logic [POS_WIDE-1:0] w;
    w = POS_WIDE'(p);
    return w[OUT_POS_W-1:0];
  endfunction

endpackage

/* rtl/core/kfsd_datapath.sv */
// Datapath: slot memory, index and fill registers, sort carry and result registers.
`timescale 1ns / 1ps

module kfsd_datapath
  import kfsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   action,
  input  logic [KEY_W-1:0]       key,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  output logic                   strobe,
  output logic [STATUS_W-1:0]    status,
  output logic [KEY_W-1:0]       entry_key,
  output logic [OUT_COUNT_W-1:0] entry_count,
  output logic [OUT_POS_W-1:0]   entry_position,
  output logic                   last
);

  entry_t                mem [CAPACITY];
  entry_t                rd;
  entry_t                cur;
  entry_t                wdata;
  logic [ADDR_W-1:0]     waddr;
  logic [ADDR_W-1:0]     idx;
  logic [USED_W-1:0]     used;
  logic [USED_W-1:0]     used_m1;
  logic                  swapped;
  logic                  action_r;
  logic [KEY_W-1:0]      key_r;
  logic [COUNT_BITS-1:0] bump;

  // Saturating increment of the count just read.
  assign bump    = (rd.count == COUNT_MAX) ? rd.count : rd.count + COUNT_BITS'(1);
  assign used_m1 = used - USED_W'(1);

  // Status toward the controller.
  assign stat.action  = action_r;
  assign stat.empty   = (used == '0);
  assign stat.full    = (used == USED_W'(CAPACITY));
  assign stat.at_last = (USED_W'(idx) == used_m1);
  assign stat.hit     = (rd.key == key_r);
  assign stat.less    = (cur.count < rd.count);
  assign stat.swapped = swapped;

  // Write address and data selection.
  always_comb begin
    case (cmd.wsel)
      WA_PREV: waddr = idx - ADDR_W'(1);
      WA_IDX:  waddr = idx;
      WA_USED: waddr = ADDR_W'(used);
      default: waddr = idx;
    endcase
    case (cmd.wdat)
      WD_READ: wdata = rd;
      WD_CUR:  wdata = cur;
      WD_NEW:  wdata = '{key: key_r, count: COUNT_BITS'(1)};
      WD_BUMP: wdata = '{key: key_r, count: bump};
      default: wdata = rd;
    endcase
  end

  // Slot memory: one write port, one registered read port at the index.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[waddr] <= wdata;
    end
    rd <= mem[idx];
  end

  // Item latch and sort carry register.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action;
      key_r    <= key;
    end
    if (cmd.cur_load) begin
      cur <= rd;
    end
  end

  // Index, fill count and swap flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx     <= '0;
      used    <= '0;
      swapped <= 1'b0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + ADDR_W'(1);
      end
      if (cmd.used_inc) begin
        used <= used + USED_W'(1);
      end
      if (cmd.swap_clr) begin
        swapped <= 1'b0;
      end else if (cmd.swap_set) begin
        swapped <= 1'b1;
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        EM_RAISED: begin
          status         <= ST_RAISED;
          entry_key      <= key_r;
          entry_count    <= to_out_count(bump);
          entry_position <= to_out_pos(idx);
          last           <= 1'b1;
        end
        EM_NEW: begin
          status         <= ST_NEW;
          entry_key      <= key_r;
          entry_count    <= to_out_count(COUNT_BITS'(1));
          entry_position <= to_out_pos(ADDR_W'(used));
          last           <= 1'b1;
        end
        EM_DROP: begin
          status         <= ST_DROP;
          entry_key      <= key_r;
          entry_count    <= '0;
          entry_position <= '0;
          last           <= 1'b1;
        end
        EM_DUMP: begin
          status         <= ST_DUMP;
          entry_key      <= rd.key;
          entry_count    <= to_out_count(rd.count);
          entry_position <= to_out_pos(idx);
          last           <= stat.at_last;
        end
        default: begin
          status         <= ST_EMPTY;
          entry_key      <= '0;
          entry_count    <= '0;
          entry_position <= '0;
          last           <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* rtl/core/kfsd_ctrl.sv */
// Controller: sequences lookup, append, bubble sort passes and the dump walk.
`timescale 1ns / 1ps

module kfsd_ctrl
  import kfsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_L_RD,
    S_L_CMP,
    S_S_RD0,
    S_S_LOAD,
    S_S_RD,
    S_S_CMP,
    S_S_END,
    S_D_RD,
    S_D_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      // Slot zero is read at the end of this cycle.
      S_DISPATCH: begin
        if (!stat.action) begin
          if (stat.empty) begin
            cmd.we       = 1'b1;
            cmd.wsel     = WA_USED;
            cmd.wdat     = WD_NEW;
            cmd.used_inc = 1'b1;
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_NEW;
            state_next   = S_IDLE;
          end else begin
            state_next = S_L_CMP;
          end
        end else begin
          if (stat.empty) begin
            cmd.emit     = 1'b1;
            cmd.emit_sel = EM_EMPTY;
            state_next   = S_IDLE;
          end else begin
            cmd.swap_clr = 1'b1;
            state_next   = S_S_LOAD;
          end
        end
      end
      S_L_RD: begin
        state_next = S_L_CMP;
      end
      // Compare one slot against the key; append or drop after the last one.
      S_L_CMP: begin
        if (stat.hit) begin
          cmd.we       = 1'b1;
          cmd.wsel     = WA_IDX;
          cmd.wdat     = WD_BUMP;
          cmd.emit     = 1'b1;
          cmd.emit_sel = EM_RAISED;
          state_next   = S_IDLE;
        end else if (stat.at_last) begin
          cmd.emit = 1'b1;
          if (stat.full) begin
            cmd.emit_sel = EM_DROP;
          end else begin
            cmd.we       = 1'b1;
            cmd.wsel     = WA_USED;
            cmd.wdat     = WD_NEW;
            cmd.used_inc = 1'b1;
            cmd.emit_sel = EM_NEW;
          end
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_L_RD;
        end
      end
      S_S_RD0: begin
        state_next = S_S_LOAD;
      end
      // Take slot zero as the carried entry of a new pass, or go to the dump if it is the only entry.
      S_S_LOAD: begin
        if (stat.at_last) begin
          cmd.idx_clr = 1'b1;
          state_next  = S_D_RD;
        end else begin
          cmd.cur_load = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_next   = S_S_RD;
        end
      end
      S_S_RD: begin
        state_next = S_S_CMP;
      end
      // The larger count moves left; equal counts keep their order.
      S_S_CMP: begin
        cmd.we   = 1'b1;
        cmd.wsel = WA_PREV;
        if (stat.less) begin
          cmd.wdat     = WD_READ;
          cmd.swap_set = 1'b1;
        end else begin
          cmd.wdat     = WD_CUR;
          cmd.cur_load = 1'b1;
        end
        if (stat.at_last) begin
          state_next = S_S_END;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_S_RD;
        end
      end
      // Park the carried entry in the last slot; repeat while anything moved.
      S_S_END: begin
        cmd.we      = 1'b1;
        cmd.wsel    = WA_IDX;
        cmd.wdat    = WD_CUR;
        cmd.idx_clr = 1'b1;
        if (stat.swapped) begin
          cmd.swap_clr = 1'b1;
          state_next   = S_S_RD0;
        end else begin
          state_next = S_D_RD;
        end
      end
      S_D_RD: begin
        state_next = S_D_OUT;
      end
      S_D_OUT: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EM_DUMP;
        if (stat.at_last) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_D_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/key_frequency_table_sorted_dump.sv */
// Top level of the key frequency table with sorted dump.
`timescale 1ns / 1ps
`include "key_frequency_table_sorted_dump_assert.svh"

// An item is taken at a clock edge where start is high and busy is low; one
// item is worked on at a time. Each result appears for exactly one cycle,
// marked by strobe, and the receiver cannot stall it, so it must take every
// transfer as it comes. The table lives in a memory with one write port and
// one registered read port, and each slot visit is a read and then a compare
// on that port. A record of a key walks the slots from slot zero until the
// key is found, or to the last slot for a new or dropped key; an empty table
// takes a new key in slot zero straight from dispatch. A dump sorts in place
// with stable bubble passes, the dispatch cycle standing in for the read of
// the first pass, repeated until a pass moves nothing (at most used passes),
// and then emits one result per slot in slot order. A table with one entry
// skips the passes. A dump of an empty table gives a single empty result.
// Each strobe is registered and comes in the cycle after the one that
// produced it.

module key_frequency_table_sorted_dump
  import kfsd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   action,
  input  logic [KEY_W-1:0]       key,
  output logic                   strobe,
  output logic [STATUS_W-1:0]    status,
  output logic [KEY_W-1:0]       entry_key,
  output logic [OUT_COUNT_W-1:0] entry_count,
  output logic [OUT_POS_W-1:0]   entry_position,
  output logic                   last
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  kfsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Table storage and result registers.
  kfsd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .action         (action),
    .key            (key),
    .cmd            (cmd),
    .stat           (stat),
    .strobe         (strobe),
    .status         (status),
    .entry_key      (entry_key),
    .entry_count    (entry_count),
    .entry_position (entry_position),
    .last           (last)
  );

  // An accepted item always keeps the block busy in the cycle after it is taken.
  `KFSD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start work")
  // The final result of an item leaves the block ready for the next one.
  `KFSD_ASSERT_SAME(a_last_idle, strobe && last, !busy, "busy after final result")
  // More results are pending after a result without the last mark.
  `KFSD_ASSERT_SAME(a_more_busy, strobe && !last, busy, "idle with results pending")
  // A result only follows a cycle of work.
  `KFSD_ASSERT_SAME(a_strobe_src, strobe, $past(busy), "result without work")

endmodule

/* test/testbench.sv */
// Self-checking testbench for the key frequency table with its sorted dump.
`timescale 1ns / 1ps

module testbench;
  import kfsd_pkg::*;

  // Input action codes.
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_DUMP   = 1'b1;

  localparam int RANDOM_OPS     = 300;
  localparam int HOT_KEY_OPS    = 8;
  localparam int DRAIN_CYCLES   = 300;

  // One command waiting to be driven, with the idle cycles that come before it.
  typedef struct {
    logic             act;
    logic [KEY_W-1:0] k;
    int unsigned      idle;
  } op_t;

  // One result the table is due to produce.
  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [KEY_W-1:0]       key;
    logic [OUT_COUNT_W-1:0] count;
    logic [OUT_POS_W-1:0]   pos;
    logic                   last;
  } entry_report_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic                   busy;
  logic                   action = ACT_RECORD;
  logic [KEY_W-1:0]       key = '0;
  logic                   strobe;
  logic [STATUS_W-1:0]    status;
  logic [KEY_W-1:0]       entry_key;
  logic [OUT_COUNT_W-1:0] entry_count;
  logic [OUT_POS_W-1:0]   entry_position;
  logic                   last;

  op_t                    queued_ops[$];
  entry_report_t          due_entries[$];
  int unsigned            idle_done = 0;
  logic                   xfer_seen = 1'b0;
  int unsigned            fail_count = 0;

  // Shadow copy of the frequency table.
  logic [KEY_W-1:0]       shadow_keys[CAPACITY];
  logic [COUNT_BITS-1:0]  shadow_counts[CAPACITY];
  int unsigned            shadow_used = 0;

  key_frequency_table_sorted_dump dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .key            (key),
    .strobe         (strobe),
    .status         (status),
    .entry_key      (entry_key),
    .entry_count    (entry_count),
    .entry_position (entry_position),
    .last           (last)
  );

  always #5 clk = ~clk;

  // Counts a failure; every failure is printed.
  function automatic bit log_failure();
    fail_count++;
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      if (log_failure())
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  function automatic void queue_entry(input logic [STATUS_W-1:0] st,
                                      input logic [KEY_W-1:0] k,
                                      input logic [COUNT_BITS-1:0] c,
                                      input int unsigned p, input logic lst);
    entry_report_t r;
    r.status = st;
    r.key    = k;
    r.count  = OUT_COUNT_W'(c);
    r.pos    = OUT_POS_W'(p);
    r.last   = lst;
    due_entries.push_back(r);
  endfunction

  // Applies one accepted command to the shadow table and queues its results.
  function automatic void tally_and_dump(input logic act, input logic [KEY_W-1:0] k);
    int                    hit;
    int                    j;
    logic [KEY_W-1:0]      mk;
    logic [COUNT_BITS-1:0] mc;
    hit = -1;
    if (act == ACT_RECORD) begin
      for (int i = 0; i < shadow_used; i++)
        if (hit < 0 && shadow_keys[i] == k) hit = i;
      if (hit >= 0) begin
        if (shadow_counts[hit] != COUNT_MAX) shadow_counts[hit]++;
        queue_entry(ST_RAISED, k, shadow_counts[hit], hit, 1'b1);
      end else if (shadow_used >= CAPACITY) begin
        queue_entry(ST_DROP, k, '0, 0, 1'b1);
      end else begin
        shadow_keys[shadow_used]   = k;
        shadow_counts[shadow_used] = COUNT_BITS'(1);
        queue_entry(ST_NEW, k, COUNT_BITS'(1), shadow_used, 1'b1);
        shadow_used++;
      end
    end else if (shadow_used == 0) begin
      queue_entry(ST_EMPTY, '0, '0, 0, 1'b1);
    end else begin
      // Stable insertion sort, largest count first.
      for (int i = 1; i < shadow_used; i++) begin
        mk = shadow_keys[i];
        mc = shadow_counts[i];
        j  = i;
        while (j > 0 && shadow_counts[j-1] < mc) begin
          shadow_keys[j]   = shadow_keys[j-1];
          shadow_counts[j] = shadow_counts[j-1];
          j--;
        end
        shadow_keys[j]   = mk;
        shadow_counts[j] = mc;
      end
      for (int i = 0; i < shadow_used; i++)
        queue_entry(ST_DUMP, shadow_keys[i], shadow_counts[i], i, i == shadow_used - 1);
    end
  endfunction

  function automatic void add_op(input logic act, input logic [KEY_W-1:0] k,
                                 input int unsigned idle);
    op_t o;
    o.act  = act;
    o.k    = k;
    o.idle = idle;
    queued_ops.push_back(o);
  endfunction

  // Driver: presents the next command once the previous transfer has happened.
  always @(negedge clk) begin : drive_ops
    op_t o;
    if (!rst && (!start || xfer_seen)) begin
      if (queued_ops.size() == 0) begin
        start <= 1'b0;
      end else if (idle_done < queued_ops[0].idle) begin
        start     <= 1'b0;
        idle_done <= idle_done + 1;
      end else begin
        o = queued_ops.pop_front();
        start     <= 1'b1;
        action    <= o.act;
        key       <= o.k;
        idle_done <= 0;
      end
    end
  end

  // Monitor: checks each result strobe, then predicts for an accepted command.
  always @(posedge clk) begin : watch_results
    entry_report_t want;
    if (rst) begin
      xfer_seen <= 1'b0;
    end else begin
      if (strobe) begin
        if (due_entries.size() == 0) begin
          if (log_failure())
            $error("unexpected result: status %0d key %0d count %0d position %0d",
                   status, entry_key, entry_count, entry_position);
        end else begin
          want = due_entries.pop_front();
          check_field("status", want.status, status);
          check_field("entry_key", want.key, entry_key);
          check_field("entry_count", want.count, entry_count);
          check_field("entry_position", want.pos, entry_position);
          check_field("last", want.last, last);
        end
      end
      if (start && !busy) tally_and_dump(action, key);
      xfer_seen <= start && !busy;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int unsigned burst_left;
    int unsigned gap;
    logic        act;
    logic [KEY_W-1:0] k;

    // Empty dump, then a short back to back run of key 0 in slot 0.
    add_op(ACT_DUMP, 8'hFF, 0);
    for (int n = 0; n < HOT_KEY_OPS; n++)
      add_op(ACT_RECORD, 8'h00, 0);
    add_op(ACT_DUMP, 8'h00, 1);

    // Directed: key extremes, ties, reordering and an already sorted dump.
    add_op(ACT_RECORD, 8'hFF, 2);
    add_op(ACT_RECORD, 8'h55, 0);
    add_op(ACT_RECORD, 8'hAA, 3);
    add_op(ACT_RECORD, 8'hAA, 0);
    add_op(ACT_RECORD, 8'hFF, 1);
    add_op(ACT_RECORD, 8'hAA, 0);
    add_op(ACT_RECORD, 8'h01, 0);
    add_op(ACT_RECORD, 8'h80, 4);
    add_op(ACT_DUMP, 8'h00, 0);
    add_op(ACT_RECORD, 8'h80, 0);
    add_op(ACT_RECORD, 8'h80, 0);
    add_op(ACT_RECORD, 8'h80, 0);
    add_op(ACT_RECORD, 8'h55, 2);
    add_op(ACT_DUMP, 8'h7F, 0);
    add_op(ACT_DUMP, 8'hFF, 5);
    add_op(ACT_RECORD, 8'h00, 0);

    // Random: bursts with gaps, hot keys for hits, the full range to fill the table.
    burst_left = 0;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        gap = 0;
      end
      burst_left--;
      if ($urandom_range(0, 9) == 0) begin
        act = ACT_DUMP;
        k   = KEY_W'($urandom);
      end else begin
        act = ACT_RECORD;
        k   = $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 47))
                                   : KEY_W'($urandom_range(0, 255));
      end
      add_op(act, k, gap);
    end
    add_op(ACT_DUMP, 8'h00, 0);

    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for every transfer, every due result, then a quiet stretch.
    while (queued_ops.size() != 0 || start) @(posedge clk);
    while (due_entries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake or missing results.
  initial begin : watchdog
    #100ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
